### sv/mf_pkg.sv
package mf_pkg;

  // APB address width: one 32-bit register at byte address 0
  localparam int unsigned AddrW         = 2;
  localparam int unsigned RegMaxPayload = 0;

  localparam logic [15:0] PayloadReset = 16'd1024;

  // queue between front and back
  localparam int unsigned QueueDepth = 2;

  // fragment count fits 16 bits once the limit check passed: one quotient bit per step
  localparam int unsigned DivSteps = 16;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_EMPTY    = 2'd1,
    ST_TOO_MANY = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    FR_IDLE,
    FR_DIV,
    FR_PUSH
  } front_e;

  // classified word handed from front to back
  typedef struct packed {
    logic [7:0]  data_byte;
    logic [31:0] length;
    logic        start;
    status_e     status;
    logic [15:0] payload;
    logic [15:0] count;
  } cmd_t;

  typedef struct packed {
    logic [31:0] msg_id;
    logic [15:0] frag_index;
    logic [15:0] fragment_count;
    logic [31:0] msg_bytes;
    logic [15:0] fragment_bytes;
    logic [7:0]  payload_byte;
    logic        first_in_fragment;
    logic        last_in_fragment;
    status_e     status;
  } res_t;

endpackage

### sv/mf_if.sv
interface mf_in_if;
  logic        valid;
  logic        ready;
  logic [7:0]  data_byte;
  logic [31:0] message_length;
  logic        start_of_message;

  modport source (output valid, data_byte, message_length, start_of_message, input ready);
  modport sink   (input valid, data_byte, message_length, start_of_message, output ready);
endinterface

interface mf_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] msg_id;
  logic [15:0] frag_index;
  logic [15:0] fragment_count;
  logic [31:0] msg_bytes;
  logic [15:0] fragment_bytes;
  logic [7:0]  payload_byte;
  logic        first_in_fragment;
  logic        last_in_fragment;
  logic [1:0]  status;

  modport source (output valid, msg_id, frag_index, fragment_count, msg_bytes,
                  fragment_bytes, payload_byte, first_in_fragment, last_in_fragment,
                  status, input ready);
  modport sink   (input valid, msg_id, frag_index, fragment_count, msg_bytes,
                  fragment_bytes, payload_byte, first_in_fragment, last_in_fragment,
                  status, output ready);
endinterface

### sv/message_fragmenter.sv
// Message fragmenter.
// msg_i takes one message byte per word with the message length and a start
// flag; frag_o gives one word per payload byte, tagged with message id,
// fragment index/count, total size, fragment size and first/last marks, or
// a single error word for an empty message or one needing over 65535
// fragments (its remaining bytes are then dropped). max_payload is set over
// the APB port at address 0 and is sampled on each start byte.
// Throughput: a continuation byte is taken every cycle while the front is idle
// and the queue is not full. A good start byte holds msg_i while the fragment
// count is worked out: a ceiling division done by a 16-step shift-subtract
// divider in the front, one quotient bit a cycle. Empty and oversized starts
// go straight to the queue. A continuation byte passes the queue, then the
// output register; a good start byte passes the divider first.
// A queue of QueueDepth words parts front and back, so the front keeps
// taking bytes while a result waits in the output register; when frag_o
// stalls, the queue fills and then msg_i.ready drops.
// Reset clears all message state, sets the next id to 1 and max_payload to
// 1024; no item is in flight after reset.
module message_fragmenter #(
  parameter int unsigned QueueDepth = mf_pkg::QueueDepth
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  mf_in_if.sink                    msg_i,
  mf_out_if.source                 frag_o,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [mf_pkg::AddrW-1:0] paddr,
  input  logic [31:0]              pwdata,
  output logic [31:0]              prdata,
  output logic                     pready
);

  logic [15:0]  max_payload_q;
  logic         sel_reg, cfg_wr;
  logic         push, full, q_valid, pop;
  mf_pkg::cmd_t push_cmd, q_cmd;

  assign sel_reg = paddr == mf_pkg::AddrW'(mf_pkg::RegMaxPayload * 4);
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready && sel_reg;
  assign prdata  = sel_reg ? {16'd0, max_payload_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_payload_q <= mf_pkg::PayloadReset;
    end else if (cfg_wr) begin
      max_payload_q <= pwdata[15:0];
    end
  end

  mf_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .msg_i         (msg_i),
    .max_payload_i (max_payload_q),
    .full_i        (full),
    .push_o        (push),
    .push_cmd_o    (push_cmd)
  );

  mf_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_cmd),
    .full_o      (full),
    .pop_i       (pop),
    .valid_o     (q_valid),
    .data_o      (q_cmd)
  );

  mf_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_valid_i (q_valid),
    .q_cmd_i   (q_cmd),
    .pop_o     (pop),
    .frag_o    (frag_o)
  );

endmodule

### sv/mf_front.sv
module mf_front (
  input  logic           clk_i,
  input  logic           rst_ni,
  mf_in_if.sink          msg_i,
  input  logic [15:0]    max_payload_i,
  input  logic           full_i,
  output logic           push_o,
  output mf_pkg::cmd_t   push_cmd_o
);

  localparam int unsigned CntW = $clog2(mf_pkg::DivSteps);

  mf_pkg::front_e state_q, state_d;
  mf_pkg::cmd_t   cmd_q, in_cmd;
  logic [32:0]    rem_q, dsr_q;
  logic [15:0]    quo_q;
  logic [CntW-1:0] cnt_q;

  logic [15:0] pay;
  logic [31:0] limit;
  logic        accept, needs_div, ge;

  assign pay   = (max_payload_i == 16'd0) ? 16'd1 : max_payload_i;
  // largest length that still fits in 65535 fragments: pay * 65535
  assign limit = {pay, 16'h0000} - {16'h0000, pay};

  always_comb begin
    in_cmd.data_byte = msg_i.data_byte;
    in_cmd.length    = msg_i.message_length;
    in_cmd.start     = msg_i.start_of_message;
    in_cmd.payload   = pay;
    in_cmd.count     = 16'd0;
    if (!msg_i.start_of_message) begin
      in_cmd.status = mf_pkg::ST_OK;
    end else if (msg_i.message_length == 32'd0) begin
      in_cmd.status = mf_pkg::ST_EMPTY;
    end else if (msg_i.message_length > limit) begin
      in_cmd.status = mf_pkg::ST_TOO_MANY;
    end else begin
      in_cmd.status = mf_pkg::ST_OK;
    end
  end

  assign needs_div   = in_cmd.start && (in_cmd.status == mf_pkg::ST_OK);
  assign msg_i.ready = (state_q == mf_pkg::FR_IDLE) && !full_i;
  assign accept      = msg_i.valid && msg_i.ready;
  assign ge          = rem_q >= dsr_q;

  always_comb begin
    state_d    = state_q;
    push_o     = 1'b0;
    push_cmd_o = in_cmd;
    case (state_q)
      mf_pkg::FR_IDLE: begin
        if (accept) begin
          if (needs_div) begin
            state_d = mf_pkg::FR_DIV;
          end else begin
            push_o = 1'b1;
          end
        end
      end
      mf_pkg::FR_DIV: begin
        if (cnt_q == CntW'(mf_pkg::DivSteps - 1)) begin
          state_d = mf_pkg::FR_PUSH;
        end
      end
      mf_pkg::FR_PUSH: begin
        push_cmd_o       = cmd_q;
        push_cmd_o.count = quo_q;
        push_o           = !full_i;
        if (!full_i) begin
          state_d = mf_pkg::FR_IDLE;
        end
      end
      default: begin
        state_d = mf_pkg::FR_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= mf_pkg::FR_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      if (accept && needs_div) begin
        cnt_q <= '0;
      end else if (state_q == mf_pkg::FR_DIV) begin
        cnt_q <= cnt_q + 1'b1;
      end
    end
  end

  // restoring division of (len + pay - 1) by pay, quotient MSB first
  always_ff @(posedge clk_i) begin
    if (accept && needs_div) begin
      cmd_q <= in_cmd;
      rem_q <= {1'b0, in_cmd.length} + {17'd0, pay} - 33'd1;
      dsr_q <= {2'b00, pay, 15'd0};
    end else if (state_q == mf_pkg::FR_DIV) begin
      if (ge) begin
        rem_q <= rem_q - dsr_q;
      end
      quo_q <= {quo_q[14:0], ge};
      dsr_q <= dsr_q >> 1;
    end
  end

endmodule

### sv/mf_queue.sv
module mf_queue #(
  parameter int unsigned Depth = mf_pkg::QueueDepth
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         push_i,
  input  mf_pkg::cmd_t push_data_i,
  output logic         full_o,
  input  logic         pop_i,
  output logic         valid_o,
  output mf_pkg::cmd_t data_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  mf_pkg::cmd_t    mem [Depth];
  logic [PtrW-1:0] wr_q, rd_q;
  logic [CntW-1:0] cnt_q;
  logic            do_push, do_pop;

  assign full_o  = cnt_q == CntW'(Depth);
  assign valid_o = cnt_q != '0;
  assign data_o  = mem[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= (wr_q == PtrW'(Depth - 1)) ? '0 : wr_q + 1'b1;
      end
      if (do_pop) begin
        rd_q <= (rd_q == PtrW'(Depth - 1)) ? '0 : rd_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem[wr_q] <= push_data_i;
    end
  end

endmodule

### sv/mf_back.sv
module mf_back (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         q_valid_i,
  input  mf_pkg::cmd_t q_cmd_i,
  output logic         pop_o,
  mf_out_if.source     frag_o
);

  logic [31:0] next_id_q, next_id_d;
  logic [31:0] active_id_q, active_id_d;
  logic [31:0] total_q, total_d;
  logic [15:0] frag_cnt_q, frag_cnt_d;
  logic [15:0] cur_frag_q, cur_frag_d;
  logic [31:0] left_msg_q, left_msg_d;
  logic [15:0] left_frag_q, left_frag_d;
  logic [15:0] frag_size_q, frag_size_d;
  logic [15:0] pay_q, pay_d;
  logic        drop_q, drop_d;
  logic        out_valid_q, out_valid_d;
  mf_pkg::res_t res_q, res_d;
  logic        emit, go;

  assign pop_o = q_valid_i && (!out_valid_q || frag_o.ready);

  always_comb begin
    next_id_d   = next_id_q;
    active_id_d = active_id_q;
    total_d     = total_q;
    frag_cnt_d  = frag_cnt_q;
    cur_frag_d  = cur_frag_q;
    left_msg_d  = left_msg_q;
    left_frag_d = left_frag_q;
    frag_size_d = frag_size_q;
    pay_d       = pay_q;
    drop_d      = drop_q;
    res_d       = res_q;
    emit        = 1'b0;
    go          = 1'b0;

    if (pop_o) begin
      if (q_cmd_i.start) begin
        left_msg_d  = 32'd0;
        left_frag_d = 16'd0;
        drop_d      = 1'b0;
        case (q_cmd_i.status)
          mf_pkg::ST_EMPTY: begin
            emit         = 1'b1;
            res_d        = '0;
            res_d.status = mf_pkg::ST_EMPTY;
          end
          mf_pkg::ST_TOO_MANY: begin
            emit            = 1'b1;
            drop_d          = 1'b1;
            res_d           = '0;
            res_d.msg_bytes = q_cmd_i.length;
            res_d.status    = mf_pkg::ST_TOO_MANY;
          end
          default: begin
            go          = 1'b1;
            active_id_d = next_id_q;
            next_id_d   = next_id_q + 32'd1;
            pay_d       = q_cmd_i.payload;
            total_d     = q_cmd_i.length;
            frag_cnt_d  = q_cmd_i.count;
            cur_frag_d  = 16'd0;
            left_msg_d  = q_cmd_i.length;
            frag_size_d = (q_cmd_i.length < {16'd0, q_cmd_i.payload}) ?
                          q_cmd_i.length[15:0] : q_cmd_i.payload;
            left_frag_d = frag_size_d;
          end
        endcase
      end else if (!drop_q && left_msg_q != 32'd0 && left_frag_q != 16'd0) begin
        go = 1'b1;
      end

      if (go) begin
        emit                    = 1'b1;
        res_d.msg_id            = active_id_d;
        res_d.frag_index        = cur_frag_d;
        res_d.fragment_count    = frag_cnt_d;
        res_d.msg_bytes         = total_d;
        res_d.fragment_bytes    = frag_size_d;
        res_d.payload_byte      = q_cmd_i.data_byte;
        res_d.first_in_fragment = left_frag_d == frag_size_d;
        res_d.last_in_fragment  = left_frag_d == 16'd1;
        res_d.status            = mf_pkg::ST_OK;
        left_frag_d = left_frag_d - 16'd1;
        left_msg_d  = left_msg_d - 32'd1;
        // open the next fragment
        if (left_frag_d == 16'd0 && left_msg_d != 32'd0) begin
          cur_frag_d  = cur_frag_d + 16'd1;
          frag_size_d = (left_msg_d < {16'd0, pay_d}) ? left_msg_d[15:0] : pay_d;
          left_frag_d = frag_size_d;
        end
      end
    end

    if (emit) begin
      out_valid_d = 1'b1;
    end else if (frag_o.ready) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      next_id_q   <= 32'd1;
      active_id_q <= '0;
      total_q     <= '0;
      frag_cnt_q  <= '0;
      cur_frag_q  <= '0;
      left_msg_q  <= '0;
      left_frag_q <= '0;
      frag_size_q <= '0;
      pay_q       <= '0;
      drop_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      next_id_q   <= next_id_d;
      active_id_q <= active_id_d;
      total_q     <= total_d;
      frag_cnt_q  <= frag_cnt_d;
      cur_frag_q  <= cur_frag_d;
      left_msg_q  <= left_msg_d;
      left_frag_q <= left_frag_d;
      frag_size_q <= frag_size_d;
      pay_q       <= pay_d;
      drop_q      <= drop_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      res_q <= res_d;
    end
  end

  assign frag_o.valid             = out_valid_q;
  assign frag_o.msg_id            = res_q.msg_id;
  assign frag_o.frag_index        = res_q.frag_index;
  assign frag_o.fragment_count    = res_q.fragment_count;
  assign frag_o.msg_bytes         = res_q.msg_bytes;
  assign frag_o.fragment_bytes    = res_q.fragment_bytes;
  assign frag_o.payload_byte      = res_q.payload_byte;
  assign frag_o.first_in_fragment = res_q.first_in_fragment;
  assign frag_o.last_in_fragment  = res_q.last_in_fragment;
  assign frag_o.status            = res_q.status;

  a_frag_le_size: assert property (@(posedge clk_i) disable iff (!rst_ni)
    left_frag_q <= frag_size_q)
    else $error("fragment bytes left exceed fragment size");

  a_frag_le_msg: assert property (@(posedge clk_i) disable iff (!rst_ni)
    {16'd0, left_frag_q} <= left_msg_q)
    else $error("fragment bytes left exceed message bytes left");

  a_ok_start_clears_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop_o && q_cmd_i.start && q_cmd_i.status == mf_pkg::ST_OK) |=> !drop_q)
    else $error("dropping still set after a good start word");

  a_index_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (left_msg_q != 32'd0) |-> (cur_frag_q < frag_cnt_q))
    else $error("fragment index beyond fragment count");

  a_error_fields_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && res_q.status != mf_pkg::ST_OK) |->
      (res_q.msg_id == 32'd0 && res_q.payload_byte == 8'd0 &&
       res_q.fragment_count == 16'd0))
    else $error("error word carries header fields");

endmodule
